FILE: rtl/core/keyed_cooldown_table_core_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the keyed cooldown table core
// Shared concurrent assertion forms on clk and active-low rst_n.
// -----------------------------------------------------------------------------
`ifndef KEYED_COOLDOWN_TABLE_CORE_ASSERT_SVH
`define KEYED_COOLDOWN_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define KCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/kct_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kct_pkg
// Types and constants shared by the keyed cooldown table core.
// -----------------------------------------------------------------------------
package kct_pkg;

  localparam int KEY_W           = 48;
  localparam int STAMP_W         = 32;
  localparam int COOL_W          = 16;
  localparam int ACT_W           = 2;
  localparam int ENTRY_W         = KEY_W + STAMP_W;
  localparam int DEF_TABLE_SLOTS = 24;

  localparam logic [STAMP_W-1:0] MS_PER_SEC = STAMP_W'(1000);

  // Action codes carried by an input item.
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RECORD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] now_ms;
  } kct_in_t;

  typedef struct packed {
    logic in_cooldown;
    logic stored;
  } kct_out_t;

endpackage

FILE: rtl/core/keyed_cooldown_table_core.sv
`timescale 1ns / 1ps
// Sequence: a query or record scans the entries in order up to a hit or the last
// entry; a record then writes if it has a slot. A clear or an unused action code
// goes straight to the result. Throughput: one item at a time, scanned one entry per
// cycle; the input opens again in the cycle after the result moves out.
// Reset: valid marks and the cooldown register clear at once; no clearing pass,
// and RAM contents stay undefined until written.
// -----------------------------------------------------------------------------
// keyed_cooldown_table_core
// Per-key cooldown table: configuration register, scan sequencer, result stage.
// -----------------------------------------------------------------------------
module keyed_cooldown_table_core #(
  parameter int TABLE_SLOTS = kct_pkg::DEF_TABLE_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  kct_pkg::kct_in_t            in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output kct_pkg::kct_out_t           out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kct_pkg::COOL_W-1:0]  cfg_data
);

  import kct_pkg::*;

  logic [COOL_W-1:0]  cooldown_r;
  logic [STAMP_W-1:0] limit_r;
  logic               out_valid_r, out_valid_nxt;
  kct_out_t           out_item_r,  out_item_nxt;
  logic               res_valid;
  logic               res_ready;
  kct_out_t           res;

  // The register can always take a write.
  assign cfg_ready = 1'b1;

  // Cooldown register and its limit in milliseconds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooldown_r <= '0;
      limit_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cooldown_r <= cfg_data;
      end
      limit_r <= STAMP_W'(cooldown_r) * MS_PER_SEC;
    end
  end

  kct_scan #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_stall (in_stall),
    .item       (in_item),
    .limit      (limit_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: takes a new result once the held one is gone.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_item_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/core/kct_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kct_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// -----------------------------------------------------------------------------
module kct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/kct_scan.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kct_scan
// Sequencer that walks the entry RAM one entry a cycle and, for a record, then updates it.
// -----------------------------------------------------------------------------
module kct_scan #(
  parameter int TABLE_SLOTS = kct_pkg::DEF_TABLE_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  kct_pkg::kct_in_t             item,
  input  logic [kct_pkg::STAMP_W-1:0]  limit,
  output logic                         res_valid,
  input  logic                         res_ready,
  output kct_pkg::kct_out_t            res
);

  import kct_pkg::*;

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t                 state_r,      state_nxt;
  logic [TABLE_SLOTS-1:0] valid_r,      valid_nxt;
  logic                   cmp_vld_r,    cmp_vld_nxt;
  logic                   free_found_r, free_found_nxt;
  logic                   hot_r,        hot_nxt;
  logic                   ok_r,         ok_nxt;
  logic [IDX_W-1:0]       rd_idx_r,     rd_idx_nxt;
  logic [IDX_W-1:0]       cmp_idx_r,    cmp_idx_nxt;
  logic [IDX_W-1:0]       free_idx_r,   free_idx_nxt;
  logic [IDX_W-1:0]       wr_idx_r,     wr_idx_nxt;
  logic [ACT_W-1:0]       act_r,        act_nxt;
  logic [KEY_W-1:0]       key_r,        key_nxt;
  logic [STAMP_W-1:0]     now_r,        now_nxt;

  logic                   ram_we;
  logic                   ram_re;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [KEY_W-1:0]       ent_key;
  logic [STAMP_W-1:0]     ent_stamp;
  logic [STAMP_W-1:0]     age;
  logic                   ent_valid;
  logic                   hit;
  logic                   last;

  // Key and stamp of every entry live in one RAM word.
  kct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // Compare the entry read in the previous cycle with the item's key.
  assign ent_key   = ram_rdata[ENTRY_W-1 -: KEY_W];
  assign ent_stamp = ram_rdata[STAMP_W-1:0];
  assign ent_valid = valid_r[cmp_idx_r];
  assign hit       = ent_valid && (ent_key == key_r);
  assign age       = now_r - ent_stamp;
  assign last      = (cmp_idx_r == LAST_IDX);

  assign ram_re    = (state_r == ST_SCAN);
  assign ram_we    = (state_r == ST_WRITE);
  assign ram_wdata = {key_r, now_r};

  assign item_stall = (state_r != ST_IDLE);
  assign res_valid  = (state_r == ST_DONE);
  assign res        = '{in_cooldown: hot_r, stored: ok_r};

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    cmp_vld_nxt    = cmp_vld_r;
    free_found_nxt = free_found_r;
    hot_nxt        = hot_r;
    ok_nxt         = ok_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    free_idx_nxt   = free_idx_r;
    wr_idx_nxt     = wr_idx_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    now_nxt        = now_r;

    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          act_nxt        = item.action;
          key_nxt        = item.key;
          now_nxt        = item.now_ms;
          rd_idx_nxt     = '0;
          cmp_vld_nxt    = 1'b0;
          free_found_nxt = 1'b0;
          hot_nxt        = 1'b0;
          ok_nxt         = 1'b0;
          case (item.action)
            ACT_QUERY, ACT_RECORD: begin
              state_nxt = ST_SCAN;
            end
            ACT_CLEAR: begin
              valid_nxt = '0;
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous entry is compared.
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = rd_idx_r;
        if (rd_idx_r != LAST_IDX) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (act_r == ACT_QUERY) begin
            if (hit) begin
              hot_nxt   = (age < limit);
              state_nxt = ST_DONE;
            end else if (last) begin
              state_nxt = ST_DONE;
            end
          end else begin
            // Record: a match wins, otherwise the lowest free entry.
            if (hit) begin
              wr_idx_nxt = cmp_idx_r;
              state_nxt  = ST_WRITE;
            end else begin
              if (!ent_valid && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = cmp_idx_r;
              end
              if (last) begin
                if (free_found_r) begin
                  wr_idx_nxt = free_idx_r;
                  state_nxt  = ST_WRITE;
                end else if (!ent_valid) begin
                  wr_idx_nxt = cmp_idx_r;
                  state_nxt  = ST_WRITE;
                end else begin
                  state_nxt = ST_DONE;
                end
              end
            end
          end
        end
      end

      ST_WRITE: begin
        valid_nxt[wr_idx_r] = 1'b1;
        ok_nxt              = 1'b1;
        state_nxt           = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered result flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      hot_r        <= 1'b0;
      ok_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      free_found_r <= free_found_nxt;
      hot_r        <= hot_nxt;
      ok_r         <= ok_nxt;
    end
  end

  // Item payload and scan indexes need no reset.
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    free_idx_r <= free_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    now_r      <= now_nxt;
  end

endmodule

FILE: rtl/core/kct_chk.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kct_chk
// Port-level checks on the keyed cooldown table core, bound to the top level.
// -----------------------------------------------------------------------------
`include "keyed_cooldown_table_core_assert.svh"

module kct_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input kct_pkg::kct_out_t out_item
);

  // An accepted item keeps the input side closed while it is worked on.
  `KCT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")

  // A new result only appears while an item was in progress.
  `KCT_ASSERT_NOW(a_result_from_item, $rose(out_valid), $past(in_stall), "result without an item")

  // A result never reports both a query hit and a record.
  `KCT_ASSERT_NOW(a_one_kind, out_valid, !(out_item.in_cooldown && out_item.stored), "mixed result")

  // A stalled result item stays put.
  `KCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "result dropped")

endmodule

bind keyed_cooldown_table_core kct_chk u_kct_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

FILE: bench/tb_keyed_cooldown_table_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_keyed_cooldown_table_core
// Self-checking bench for the keyed cooldown table core. A behavioural copy
// of the table predicts the in_cooldown and stored flags of every accepted
// item. Directed items cover the field extremes, expiry boundaries, wrap and
// clear. Random traffic then fills and refreshes the table under bursty
// input, random output stalls and one long output hold-off.
// -----------------------------------------------------------------------------
module tb_keyed_cooldown_table_core;
  import kct_pkg::*;

  localparam int SLOTS = DEF_TABLE_SLOTS;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int TRAIL_CYCLES = 32;
  localparam int PHASE_ITEMS = 265;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [STAMP_W-1:0] MS_ONES = '1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  kct_in_t           in_item;
  logic              out_valid;
  logic              out_stall;
  kct_out_t          out_item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [COOL_W-1:0] cfg_data;

  // Shadow copy of the table and the cooldown register.
  logic [KEY_W-1:0]   slot_key[SLOTS];
  logic [STAMP_W-1:0] slot_stamp[SLOTS];
  bit                 slot_live[SLOTS];
  logic [COOL_W-1:0]  cooldown_s = '0;

  kct_out_t pending_outcomes[$];

  // Random traffic state: a pool of keys and a running millisecond clock.
  logic [KEY_W-1:0]   key_pool[32];
  int                 pool_size;
  int                 fill_idx;
  logic [STAMP_W-1:0] clock_ms;
  int unsigned        step_ms;

  bit hold_req = 0;

  int fault_count = 0;
  int n_items = 0;
  int n_results = 0;
  int n_hot = 0;
  int n_dropped = 0;
  int n_clears = 0;
  int n_cfg_writes = 0;

  keyed_cooldown_table_core #(
    .TABLE_SLOTS(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int find_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < SLOTS; i++)
      if (!slot_live[i]) return i;
    return -1;
  endfunction

  function automatic logic [STAMP_W-1:0] cooldown_limit();
    return STAMP_W'(cooldown_s) * MS_PER_SEC;
  endfunction

  // Applies one item to the shadow table and returns the flags it should give.
  function automatic kct_out_t predict_outcome(kct_in_t it);
    kct_out_t           res;
    int                 slot;
    logic [STAMP_W-1:0] age;
    res = '0;
    case (it.action)
      ACT_QUERY: begin
        slot = find_slot(it.key);
        if (cooldown_s != 0 && slot >= 0) begin
          age = it.now_ms - slot_stamp[slot];
          res.in_cooldown = (age < cooldown_limit());
          n_hot += res.in_cooldown;
        end
      end
      ACT_RECORD: begin
        slot = find_slot(it.key);
        if (slot < 0) begin
          slot = free_slot();
          if (slot >= 0) slot_key[slot] = it.key;
        end
        if (slot >= 0) begin
          slot_stamp[slot] = it.now_ms;
          slot_live[slot] = 1'b1;
          res.stored = 1'b1;
        end else begin
          n_dropped++;
        end
      end
      ACT_CLEAR: begin
        foreach (slot_live[i]) slot_live[i] = 1'b0;
        n_clears++;
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    kct_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, got %b",
                 $time, out_item);
        fault_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_item.in_cooldown !== want.in_cooldown) begin
          $display("%0t: in_cooldown mismatch, expected %b, got %b",
                   $time, want.in_cooldown, out_item.in_cooldown);
          fault_count++;
        end
        if (out_item.stored !== want.stored) begin
          $display("%0t: stored mismatch, expected %b, got %b",
                   $time, want.stored, out_item.stored);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: changing stall patterns, plus one long hold-off on request.
  // ---------------------------------------------------------------------------

  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= left[1];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration helpers
  // ---------------------------------------------------------------------------

  // Offers one item and returns once it is accepted; valid stays high.
  task automatic push_item(kct_in_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pending_outcomes.push_back(predict_outcome(it));
    n_items++;
  endtask

  task automatic hold_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_idle();
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_cooldown(logic [COOL_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cooldown_s = value;
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic kct_in_t make_item(logic [ACT_W-1:0] action, logic [KEY_W-1:0] key,
                                        logic [STAMP_W-1:0] now_ms);
    kct_in_t it;
    it.action = action;
    it.key    = key;
    it.now_ms = now_ms;
    return it;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic void new_pool();
    pool_size = $urandom_range(4, 32);
    fill_idx = 0;
    for (int i = 0; i < pool_size; i++) key_pool[i] = random_key();
    if ($urandom_range(0, 9) == 0) key_pool[0] = '0;
    if ($urandom_range(0, 9) == 0) key_pool[pool_size - 1] = KEY_ONES;
  endfunction

  // Starts a traffic phase: the clock sometimes begins just below the wrap.
  function automatic void new_phase();
    clock_ms = $urandom_range(0, 1) ? ~STAMP_W'($urandom_range(0, 200000)) : $urandom;
    step_ms = (cooldown_s == 0) ? 5000 : int'(cooldown_s) * 1000 / 16 + 1;
    new_pool();
  endfunction

  // Mostly records and queries on the key pool. Half of the records walk the pool so
  // that large pools fill the table; half of the hit queries land on the expiry edge.
  function automatic kct_in_t next_item();
    kct_in_t it;
    int      pick;
    int      slot;
    pick = $urandom_range(0, 99);
    clock_ms += STAMP_W'($urandom_range(0, step_ms));
    it = make_item(ACT_QUERY, key_pool[$urandom_range(0, pool_size - 1)], clock_ms);
    if (pick < 1) begin
      it.action = ACT_CLEAR;
      it.key = random_key();
      new_pool();
    end else if (pick < 3) begin
      it.action = ACT_UNUSED;
      it.key = random_key();
    end else if (pick < 6) begin
      it.key = random_key();
    end else if (pick < 50) begin
      it.action = ACT_RECORD;
      if ($urandom_range(0, 1)) begin
        it.key = key_pool[fill_idx % pool_size];
        fill_idx++;
      end
    end else begin
      slot = find_slot(it.key);
      if (slot >= 0 && cooldown_s != 0 && $urandom_range(0, 1))
        it.now_ms = slot_stamp[slot] + cooldown_limit() + STAMP_W'($urandom_range(0, 3))
                    - STAMP_W'(2);
    end
    return it;
  endfunction

  // Sends random items in bursts of random length with random gaps between them.
  task automatic send_stream(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        hold_input($urandom_range(1, 12));
        burst = $urandom_range(1, 40);
      end
      push_item(next_item());
      burst--;
    end
    hold_input(1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Cooldown is zero out of reset, so a hit still reports nothing.
  task automatic test_cooldown_disabled();
    push_item(make_item(ACT_RECORD, 48'h0123_4567_89AB, 32'd100));
    push_item(make_item(ACT_QUERY, 48'h0123_4567_89AB, 32'd150));
    push_item(make_item(ACT_UNUSED, KEY_ONES, MS_ONES));
    hold_input(1);
  endtask

  // One second of cooldown: both sides of the limit, a miss, wrap and a refresh.
  task automatic test_expiry_edges();
    wait_idle();
    write_cooldown(16'd1);
    push_item(make_item(ACT_RECORD, KEY_ONES, 32'd0));
    push_item(make_item(ACT_QUERY, KEY_ONES, 32'd999));
    push_item(make_item(ACT_QUERY, KEY_ONES, 32'd1000));
    push_item(make_item(ACT_QUERY, 48'd0, 32'd500));
    push_item(make_item(ACT_RECORD, 48'd0, MS_ONES));
    push_item(make_item(ACT_QUERY, 48'd0, 32'd998));
    push_item(make_item(ACT_RECORD, KEY_ONES, 32'd5000));
    push_item(make_item(ACT_QUERY, KEY_ONES, 32'd5999));
    hold_input(1);
  endtask

  // Largest cooldown across the wrap of the clock, then a clear.
  task automatic test_max_cooldown_and_clear();
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
    key = 48'hA5A5_5A5A_C3C3;
    stamp = 32'hFFFF_FF00;
    wait_idle();
    write_cooldown(16'hFFFF);
    push_item(make_item(ACT_RECORD, key, stamp));
    push_item(make_item(ACT_QUERY, key, 32'h0000_1000));
    push_item(make_item(ACT_QUERY, key, stamp + 32'd65_534_999));
    push_item(make_item(ACT_QUERY, key, stamp + 32'd65_535_000));
    push_item(make_item(ACT_QUERY, KEY_ONES, 32'd0));
    push_item(make_item(ACT_CLEAR, key, 32'd0));
    push_item(make_item(ACT_QUERY, key, stamp));
    push_item(make_item(ACT_RECORD, key, 32'd0));
    hold_input(1);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_holdoff();
    new_phase();
    hold_req = 1;
    @(negedge clk);
    for (int i = 0; i < 20; i++) push_item(next_item());
    hold_input(1);
  endtask

  // Random traffic over several cooldown settings, the extremes among them.
  task automatic test_random_traffic();
    logic [COOL_W-1:0] settings[6];
    settings = '{16'd0, 16'd1, 16'hFFFF, COOL_W'($urandom_range(2, 65534)), 16'd2,
                 COOL_W'($urandom_range(2, 600))};
    foreach (settings[p]) begin
      wait_idle();
      write_cooldown(settings[p]);
      new_phase();
      send_stream(PHASE_ITEMS);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_cooldown_disabled();
    test_expiry_edges();
    test_max_cooldown_and_clear();
    test_output_holdoff();
    test_random_traffic();

    wait_idle();
    repeat (TRAIL_CYCLES) @(posedge clk);

    $display("tb: %0d items sent, %0d results checked, %0d cooldown writes",
             n_items, n_results, n_cfg_writes);
    $display("tb: %0d queries in cooldown, %0d records dropped on a full table, %0d clears",
             n_hot, n_dropped, n_clears);
    if (fault_count == 0 && pending_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/kct_pkg.sv
rtl/core/kct_ram.sv
rtl/core/kct_scan.sv
rtl/core/keyed_cooldown_table_core.sv
rtl/core/kct_chk.sv
bench/tb_keyed_cooldown_table_core.sv
